// File: rtl/assert_macros.svh
// Assertion macros used by the checker of this block.
// The macros expect signals named clk and rst_n in the scope of their use.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, checked outside reset.
`define SQP_ASSERT_IMP(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("same-cycle check failed");

// Next-cycle implication, checked outside reset.
`define SQP_ASSERT_NXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("next-cycle check failed");

`endif

// File: rtl/sqp_pkg.sv
// Package for the sorted quantile picker: sizes, request and result types,
// status codes and the sequencer state type. Depends on nothing.
package sqp_pkg;

    // Capacity of one set and the largest number of picks.
    localparam int MAX_SAMPLES = 64;
    localparam int MAX_PICKS   = 8;

    localparam int ADDR_W  = $clog2(MAX_SAMPLES);
    localparam int CNT_W   = $clog2(MAX_SAMPLES + 1);
    localparam int PICK_W  = 3;
    localparam int PCNT_W  = 4;
    localparam int REM_W   = CNT_W + 1;
    localparam int VALUE_W = 32;
    localparam int STAT_W  = 2;

    // Result status codes.
    localparam logic [STAT_W-1:0] STATUS_OK  = 2'd0;
    localparam logic [STAT_W-1:0] STATUS_FEW = 2'd1;
    localparam logic [STAT_W-1:0] STATUS_OVF = 2'd2;

    // Reset value of the pick count register.
    localparam logic [PCNT_W-1:0] PICK_COUNT_RESET = 4'd3;

    typedef struct packed {
        logic signed [VALUE_W-1:0] sample_value;
        logic                      last_sample;
    } sample_t;

    typedef struct packed {
        logic signed [VALUE_W-1:0] pick_value;
        logic [PICK_W-1:0]         pick_index;
        logic                      last_pick;
        logic [STAT_W-1:0]         status;
    } result_t;

    typedef enum logic [2:0] {
        ST_LOAD,
        ST_ERR,
        ST_CAND,
        ST_CAND_W,
        ST_SCAN,
        ST_WRITE,
        ST_DIV,
        ST_EMIT
    } state_t;

endpackage

// File: rtl/sqp_ram.sv
// Simple dual-port RAM, one write and one registered read port.
// Generic; used for the sample store and the ranked copy.
module sqp_ram #(
    parameter int DEPTH = 64,
    parameter int WIDTH = 32,
    localparam int AW = $clog2(DEPTH)
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write port.
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // Registered read port.
    always_ff @(posedge clk)
    begin
        rdata <= mem[raddr];
    end

endmodule

// File: rtl/sorted_quantile_picker_top.sv
// Top level of the sorted quantile picker: load, rank and pick sequencer.
// Depends on sqp_pkg and sqp_ram.
//
// Channel   | Ports                     | Handshake
// ----------+---------------------------+--------------------------------
// sample    | start, busy, sample       | taken when start and not busy
// result    | done, result              | one-cycle strobe, never stalled
// config    | cfg_we, cfg_data          | written when cfg_we is high
//
// A sample without last_sample leaves busy low.
// A set of n samples is then ranked through the single comparator and the
// one read port of the sample store, then its p picks are emitted through
// the shared subtract-and-compare step.
// A set with fewer samples than picks gives its one result in the next cycle.
// Reset clears the sample count, the overflow flag and the sequencer.
module sorted_quantile_picker_top
    import sqp_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    output logic              busy,
    input  sample_t           sample,
    output logic              done,
    output result_t           result,
    input  logic              cfg_we,
    input  logic [PCNT_W-1:0] cfg_data
);

    state_t state_reg, state_next;

    logic [PCNT_W-1:0] pick_count_reg;
    logic [CNT_W-1:0]  count_reg, count_next;
    logic              ovf_reg, ovf_next;
    logic [CNT_W-1:0]  n_reg, n_next;
    logic [PCNT_W-1:0] lim_reg, lim_next;
    logic [STAT_W-1:0] stat_reg, stat_next;
    logic [ADDR_W-1:0] j_reg, j_next;
    logic [ADDR_W-1:0] i_reg, i_next;
    logic [ADDR_W-1:0] rank_reg, rank_next;
    logic [VALUE_W-1:0] cand_reg, cand_next;
    logic [PICK_W-1:0] pick_reg, pick_next;
    logic [ADDR_W-1:0] q_reg, q_next;
    logic [REM_W-1:0]  r_reg, r_next;

    logic              accept;
    logic              room;
    logic [CNT_W-1:0]  n_load;
    logic [PCNT_W-1:0] lim_load;
    logic [CNT_W-1:0]  nm1_full;
    logic [ADDR_W-1:0] n_last;
    logic [PCNT_W-1:0] div_d;
    logic [REM_W-1:0]  div_d_ext;
    logic              is_last_pick;
    logic              ahead;

    logic              store_we;
    logic [ADDR_W-1:0] store_raddr;
    logic [VALUE_W-1:0] store_rdata;
    logic              rank_we;
    logic [VALUE_W-1:0] rank_rdata;

    function automatic logic cfg_data_clamp_zero(input logic [PCNT_W-1:0] v);
        return (v == '0);
    endfunction

    // Request acceptance and the load-side values.
    assign accept   = start && (state_reg == ST_LOAD);
    assign room     = (count_reg < CNT_W'(MAX_SAMPLES));
    assign n_load   = room ? count_reg + 1'b1 : count_reg;
    assign store_we = accept && room;

    always_comb
    begin
        if (cfg_data_clamp_zero(pick_count_reg))
        begin
            lim_load = PCNT_W'(1);
        end
        else if (pick_count_reg > PCNT_W'(MAX_PICKS))
        begin
            lim_load = PCNT_W'(MAX_PICKS);
        end
        else
        begin
            lim_load = pick_count_reg;
        end
    end

    // Derived values of the current set.
    assign nm1_full     = n_reg - 1'b1;
    assign n_last       = nm1_full[ADDR_W-1:0];
    assign div_d        = lim_reg - 1'b1;
    assign div_d_ext    = REM_W'(div_d);
    assign is_last_pick = (PCNT_W'(pick_reg) == div_d);

    // Shared comparator: does the scanned sample rank ahead of the candidate.
    assign ahead = ($signed(store_rdata) > $signed(cand_reg))
                   || ((store_rdata == cand_reg) && (i_reg < j_reg));

    // Sample store read address.
    always_comb
    begin
        case (state_reg)
            ST_CAND:  store_raddr = j_reg;
            ST_SCAN:  store_raddr = i_reg + 1'b1;
            default:  store_raddr = '0;
        endcase
    end

    assign rank_we = (state_reg == ST_WRITE);

    sqp_ram #(
        .DEPTH (MAX_SAMPLES),
        .WIDTH (VALUE_W)
    ) u_store (
        .clk   (clk),
        .we    (store_we),
        .waddr (count_reg[ADDR_W-1:0]),
        .wdata (sample.sample_value),
        .raddr (store_raddr),
        .rdata (store_rdata)
    );

    sqp_ram #(
        .DEPTH (MAX_SAMPLES),
        .WIDTH (VALUE_W)
    ) u_ranked (
        .clk   (clk),
        .we    (rank_we),
        .waddr (rank_reg),
        .wdata (cand_reg),
        .raddr (q_reg),
        .rdata (rank_rdata)
    );

    // Configuration register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pick_count_reg <= PICK_COUNT_RESET;
        end
        else if (cfg_we)
        begin
            pick_count_reg <= cfg_data;
        end
    end

    // State and control registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_LOAD;
            count_reg <= '0;
            ovf_reg   <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            count_reg <= count_next;
            ovf_reg   <= ovf_next;
        end
    end

    // Working registers of the set being ranked and picked.
    always_ff @(posedge clk)
    begin
        n_reg    <= n_next;
        lim_reg  <= lim_next;
        stat_reg <= stat_next;
        j_reg    <= j_next;
        i_reg    <= i_next;
        rank_reg <= rank_next;
        cand_reg <= cand_next;
        pick_reg <= pick_next;
        q_reg    <= q_next;
        r_reg    <= r_next;
    end

    // Sequencer: next state and outputs.
    always_comb
    begin
        state_next = state_reg;
        count_next = count_reg;
        ovf_next   = ovf_reg;
        n_next     = n_reg;
        lim_next   = lim_reg;
        stat_next  = stat_reg;
        j_next     = j_reg;
        i_next     = i_reg;
        rank_next  = rank_reg;
        cand_next  = cand_reg;
        pick_next  = pick_reg;
        q_next     = q_reg;
        r_next     = r_reg;
        busy       = 1'b1;
        done       = 1'b0;
        result     = '0;

        case (state_reg)
            // Load samples until the last one of the set arrives.
            ST_LOAD:
            begin
                busy = 1'b0;
                if (accept)
                begin
                    if (room)
                    begin
                        count_next = count_reg + 1'b1;
                    end
                    else
                    begin
                        ovf_next = 1'b1;
                    end
                    if (sample.last_sample)
                    begin
                        n_next     = n_load;
                        lim_next   = lim_load;
                        stat_next  = (ovf_reg || !room) ? STATUS_OVF : STATUS_OK;
                        count_next = '0;
                        ovf_next   = 1'b0;
                        j_next     = '0;
                        if (int'(n_load) < int'(lim_load))
                        begin
                            state_next = ST_ERR;
                        end
                        else
                        begin
                            state_next = ST_CAND;
                        end
                    end
                end
            end

            // Too few samples: one error result.
            ST_ERR:
            begin
                done              = 1'b1;
                result.last_pick  = 1'b1;
                result.status     = STATUS_FEW;
                state_next        = ST_LOAD;
            end

            // Fetch the candidate sample j.
            ST_CAND:
            begin
                state_next = ST_CAND_W;
            end

            // Hold the candidate and start the scan at sample 0.
            ST_CAND_W:
            begin
                cand_next  = store_rdata;
                i_next     = '0;
                rank_next  = '0;
                state_next = ST_SCAN;
            end

            // Count the samples that rank ahead of the candidate.
            ST_SCAN:
            begin
                rank_next = rank_reg + ADDR_W'(ahead);
                if (i_reg == n_last)
                begin
                    state_next = ST_WRITE;
                end
                else
                begin
                    i_next = i_reg + 1'b1;
                end
            end

            // Place the candidate at its rank.
            ST_WRITE:
            begin
                if (j_reg == n_last)
                begin
                    pick_next  = '0;
                    q_next     = '0;
                    r_next     = '0;
                    state_next = ST_DIV;
                end
                else
                begin
                    j_next     = j_reg + 1'b1;
                    state_next = ST_CAND;
                end
            end

            // One subtract step of the rank index division.
            ST_DIV:
            begin
                if ((div_d != '0) && (r_reg >= div_d_ext))
                begin
                    r_next = r_reg - div_d_ext;
                    q_next = q_reg + 1'b1;
                end
                else
                begin
                    state_next = ST_EMIT;
                end
            end

            // Emit one pick from the ranked copy.
            ST_EMIT:
            begin
                done              = 1'b1;
                result.pick_value = rank_rdata;
                result.pick_index = pick_reg;
                result.last_pick  = is_last_pick;
                result.status     = stat_reg;
                if (is_last_pick)
                begin
                    state_next = ST_LOAD;
                end
                else
                begin
                    pick_next  = pick_reg + 1'b1;
                    r_next     = r_reg + REM_W'(nm1_full);
                    state_next = ST_DIV;
                end
            end

            default:
            begin
                state_next = ST_LOAD;
            end
        endcase
    end

endmodule

// File: rtl/sqp_checker.sv
// Port-level checker for the sorted quantile picker, bound to the top level.
// Depends on sqp_pkg and assert_macros.svh.
`include "assert_macros.svh"

module sqp_checker
    import sqp_pkg::*;
(
    input logic              clk,
    input logic              rst_n,
    input logic              start,
    input logic              busy,
    input sample_t           sample,
    input logic              done,
    input result_t           result,
    input logic              cfg_we,
    input logic [PCNT_W-1:0] cfg_data
);

    logic accept;
    logic cfg_seen;

    assign accept   = start && !busy;
    assign cfg_seen = cfg_we && (cfg_data != '1);

    // Results only come out while a set is being worked on.
    `SQP_ASSERT_IMP(a_done_busy, done, busy)

    // The last sample of a set makes the block busy; other samples do not.
    `SQP_ASSERT_NXT(a_last_busy, accept && sample.last_sample, busy)
    `SQP_ASSERT_NXT(a_load_free, accept && !sample.last_sample && !cfg_seen, !busy)

    // The final result of a set frees the block.
    `SQP_ASSERT_NXT(a_end_free, done && result.last_pick, !busy)

    // The error result is a single zero pick.
    `SQP_ASSERT_IMP(a_err_form, done && (result.status == STATUS_FEW),
        result.last_pick && (result.pick_value == 0) && (result.pick_index == 0))

endmodule

bind sorted_quantile_picker_top sqp_checker u_sqp_checker (.*);
